FILE: design/irpd_pkg.sv
package irpd_pkg;

   localparam int PAIR_W = 3;
   localparam int SUM_W = 24;
   localparam int CUR_W = 16;
   localparam int TIME_W = 32;
   localparam int THR_W = 23;
   localparam int DIS_W = 16;
   localparam int DUTY_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [PAIR_W-1:0] PAIR_LIMIT = 3'd6;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_STOP = 2'd2;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RUN = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [1:0] LOW_A = 2'd0;
   localparam logic [1:0] LOW_B = 2'd1;
   localparam logic [1:0] LOW_C = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCHARGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY = 2'd2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 23'd6400;
   localparam logic [DIS_W-1:0] DISCHARGE_RESET = 16'd100;
   localparam logic [DUTY_W-1:0] DUTY_RESET = 16'd1966;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

   typedef struct packed {
      logic [1:0] run_phase;
      logic [PAIR_W-1:0] pair_index;
      logic sampling;
      logic [TIME_W-1:0] start_time;
      logic signed [SUM_W-1:0] current_sum;
      logic [TIME_W-1:0] best_time;
      logic [PAIR_W-1:0] best_pair;
   } det_state_type;

   typedef struct packed {
      logic [PAIR_W-1:0] drive_pair;
      logic drive_enable;
      logic [DUTY_W-1:0] drive_duty;
      logic rise_valid;
      logic [TIME_W-1:0] rise_time;
      logic done_res;
      logic [PAIR_W-1:0] lowest_pair;
   } det_result_type;

   typedef struct packed {
      logic [THR_W-1:0] current_threshold;
      logic [DIS_W-1:0] discharge_time_ms;
      logic [DUTY_W-1:0] drive_duty_level;
   } det_cfg_type;

   function automatic logic [1:0] low_phase(input logic [PAIR_W-1:0] pair);
      logic [1:0] ph;
      case (pair)
         3'd0: ph = LOW_C;
         3'd1: ph = LOW_B;
         3'd2: ph = LOW_B;
         3'd3: ph = LOW_A;
         3'd4: ph = LOW_A;
         3'd5: ph = LOW_C;
         default: ph = LOW_A;
      endcase
      return ph;
   endfunction

endpackage

FILE: design/inductive_rotor_position_detector.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | kind, time_ms, current_a/b/c
// rsp     | out       | rsp_valid/rsp_stall  | drive_pair .. lowest_pair
// csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// One beat in, one beat out; the beat's result is registered on acceptance and is valid in the following cycle.
// Throughput is one beat per cycle while req_stall is low, set by the single detector state update.
// req_stall is high only while a result waits and rsp_stall holds it.
// Synchronous reset returns the CSR and state registers to their defaults and the detector to idle.
module inductive_rotor_position_detector #(
   parameter int PAIR_COUNT = 6
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_kind,
   input logic [irpd_pkg::TIME_W-1:0] req_time_ms,
   input logic signed [irpd_pkg::CUR_W-1:0] req_current_a,
   input logic signed [irpd_pkg::CUR_W-1:0] req_current_b,
   input logic signed [irpd_pkg::CUR_W-1:0] req_current_c,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [irpd_pkg::PAIR_W-1:0] rsp_drive_pair,
   output logic rsp_drive_enable,
   output logic [irpd_pkg::DUTY_W-1:0] rsp_drive_duty,
   output logic rsp_rise_valid,
   output logic [irpd_pkg::TIME_W-1:0] rsp_rise_time,
   output logic rsp_done_res,
   output logic [irpd_pkg::PAIR_W-1:0] rsp_lowest_pair,
   input logic csr_wr_en,
   input logic [irpd_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [irpd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   irpd_pkg::det_cfg_type cfg_ff;
   irpd_pkg::det_state_type state_ff;
   irpd_pkg::det_state_type state_in;
   irpd_pkg::det_result_type result_in;
   irpd_pkg::det_result_type result_ff;
   logic rsp_valid_ff;
   logic req_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_threshold <= irpd_pkg::THRESHOLD_RESET;
         cfg_ff.discharge_time_ms <= irpd_pkg::DISCHARGE_RESET;
         cfg_ff.drive_duty_level <= irpd_pkg::DUTY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            irpd_pkg::CSR_THRESHOLD: cfg_ff.current_threshold <= csr_wdata;
            irpd_pkg::CSR_DISCHARGE: cfg_ff.discharge_time_ms <= csr_wdata[irpd_pkg::DIS_W-1:0];
            irpd_pkg::CSR_DUTY: cfg_ff.drive_duty_level <= csr_wdata[irpd_pkg::DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   irpd_step #(
      .PAIR_COUNT(PAIR_COUNT)
   ) u_step (
      .cur_state(state_ff),
      .cfg(cfg_ff),
      .kind(req_kind),
      .time_ms(req_time_ms),
      .current_a(req_current_a),
      .current_b(req_current_b),
      .current_c(req_current_c),
      .nxt_state(state_in),
      .result(result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.run_phase <= irpd_pkg::PH_IDLE;
         state_ff.pair_index <= '0;
         state_ff.sampling <= 1'b0;
         state_ff.start_time <= '0;
         state_ff.current_sum <= '0;
         state_ff.best_time <= '1;
         state_ff.best_pair <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_pair = result_ff.drive_pair;
   assign rsp_drive_enable = result_ff.drive_enable;
   assign rsp_drive_duty = result_ff.drive_duty;
   assign rsp_rise_valid = result_ff.rise_valid;
   assign rsp_rise_time = result_ff.rise_time;
   assign rsp_done_res = result_ff.done_res;
   assign rsp_lowest_pair = result_ff.lowest_pair;

   a_sampling_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff.sampling |-> state_ff.run_phase == irpd_pkg::PH_RUN)
      else $error("sampling outside a run");

   a_pair_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.run_phase == irpd_pkg::PH_RUN
      |-> state_ff.pair_index < irpd_pkg::PAIR_W'(PAIR_COUNT))
      else $error("pair index past last pair while running");

   a_rise_drive_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.rise_valid |-> result_ff.drive_duty == '0)
      else $error("duty applied on the beat that recorded a rise");

   a_done_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.done_res |-> !result_ff.drive_enable)
      else $error("drive enabled after completion");

endmodule

FILE: design/irpd_step.sv
module irpd_step #(
   parameter int PAIR_COUNT = 6
) (
   input irpd_pkg::det_state_type cur_state,
   input irpd_pkg::det_cfg_type cfg,
   input logic [1:0] kind,
   input logic [irpd_pkg::TIME_W-1:0] time_ms,
   input logic signed [irpd_pkg::CUR_W-1:0] current_a,
   input logic signed [irpd_pkg::CUR_W-1:0] current_b,
   input logic signed [irpd_pkg::CUR_W-1:0] current_c,
   output irpd_pkg::det_state_type nxt_state,
   output irpd_pkg::det_result_type result
);

   logic signed [irpd_pkg::CUR_W-1:0] low_cur;
   logic signed [irpd_pkg::SUM_W:0] sum_wide;
   logic signed [irpd_pkg::SUM_W-1:0] sum_sat;
   logic crossed;
   logic [irpd_pkg::TIME_W-1:0] rise;
   logic [irpd_pkg::TIME_W-1:0] elapsed;
   logic [irpd_pkg::PAIR_W-1:0] pair_next;
   logic enabled;
   logic rise_hit;
   logic [irpd_pkg::TIME_W-1:0] rise_report;

   always_comb begin
      case (irpd_pkg::low_phase(cur_state.pair_index))
         irpd_pkg::LOW_A: low_cur = current_a;
         irpd_pkg::LOW_B: low_cur = current_b;
         irpd_pkg::LOW_C: low_cur = current_c;
         default: low_cur = current_a;
      endcase
   end

   assign sum_wide = {cur_state.current_sum[irpd_pkg::SUM_W-1], cur_state.current_sum}
      + {{(irpd_pkg::SUM_W + 1 - irpd_pkg::CUR_W){low_cur[irpd_pkg::CUR_W-1]}}, low_cur};

   always_comb begin
      if (sum_wide > $signed({sum_wide[irpd_pkg::SUM_W], irpd_pkg::SUM_MAX})
          && !sum_wide[irpd_pkg::SUM_W]) begin
         sum_sat = irpd_pkg::SUM_MAX;
      end else if (sum_wide[irpd_pkg::SUM_W]
                   && sum_wide[irpd_pkg::SUM_W-1] == 1'b0) begin
         sum_sat = irpd_pkg::SUM_MIN;
      end else begin
         sum_sat = sum_wide[irpd_pkg::SUM_W-1:0];
      end
   end

   assign crossed = sum_sat > $signed({1'b0, cfg.current_threshold});
   assign rise = time_ms - cur_state.start_time;
   assign pair_next = cur_state.pair_index + 3'd1;

   always_comb begin
      nxt_state = cur_state;
      rise_hit = 1'b0;
      rise_report = '0;
      elapsed = '0;
      case (kind)
         irpd_pkg::KIND_START: begin
            nxt_state.run_phase = irpd_pkg::PH_RUN;
            nxt_state.pair_index = '0;
            nxt_state.sampling = 1'b1;
            nxt_state.start_time = time_ms;
            nxt_state.current_sum = '0;
            nxt_state.best_time = '1;
            nxt_state.best_pair = '0;
         end
         irpd_pkg::KIND_STOP: begin
            if (cur_state.run_phase != irpd_pkg::PH_DONE) begin
               nxt_state.run_phase = irpd_pkg::PH_STOP;
            end
            nxt_state.sampling = 1'b0;
         end
         irpd_pkg::KIND_SAMPLE: begin
            if (cur_state.run_phase == irpd_pkg::PH_RUN) begin
               if (cur_state.sampling && cur_state.pair_index < irpd_pkg::PAIR_LIMIT) begin
                  nxt_state.current_sum = sum_sat;
                  if (crossed) begin
                     rise_hit = 1'b1;
                     rise_report = rise;
                     if (rise < cur_state.best_time) begin
                        nxt_state.best_time = rise;
                        nxt_state.best_pair = cur_state.pair_index;
                     end
                     nxt_state.sampling = 1'b0;
                     nxt_state.start_time = time_ms;
                  end
               end
               elapsed = time_ms - nxt_state.start_time;
               if (!nxt_state.sampling
                   && elapsed > {{(irpd_pkg::TIME_W - irpd_pkg::DIS_W){1'b0}},
                                 cfg.discharge_time_ms}) begin
                  nxt_state.pair_index = pair_next;
                  if (pair_next >= irpd_pkg::PAIR_W'(PAIR_COUNT)) begin
                     nxt_state.run_phase = irpd_pkg::PH_DONE;
                  end else begin
                     nxt_state.sampling = 1'b1;
                     nxt_state.start_time = time_ms;
                     nxt_state.current_sum = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign enabled = nxt_state.run_phase == irpd_pkg::PH_RUN;
   assign result.drive_pair = enabled ? nxt_state.pair_index : '0;
   assign result.drive_enable = enabled;
   assign result.drive_duty = (enabled && nxt_state.sampling) ? cfg.drive_duty_level : '0;
   assign result.rise_valid = rise_hit;
   assign result.rise_time = rise_report;
   assign result.done_res = nxt_state.run_phase == irpd_pkg::PH_DONE;
   assign result.lowest_pair = result.done_res ? nxt_state.best_pair : '0;

endmodule
